[sv/lrcf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// LED ring clock face renderer - shared definitions
// Types, register map and reset values used across the renderer.
// ----------------------------------------------------------------------------
package lrcf_pkg;

	// ring geometry
	localparam int LED_COUNT = 60;
	localparam logic [5:0] LED_LAST = 6'(LED_COUNT - 1);

	// default depth of the frame queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// configuration port
	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_LIGHT_MIN   = 3'd0;
	localparam logic [2:0] REG_LIGHT_MAX   = 3'd1;
	localparam logic [2:0] REG_MANUAL      = 3'd2;
	localparam logic [2:0] REG_BACKGROUND  = 3'd3;
	localparam logic [2:0] REG_SECOND_COL  = 3'd4;
	localparam logic [2:0] REG_MINUTE_COL  = 3'd5;
	localparam logic [2:0] REG_HOUR_COL    = 3'd6;
	localparam logic [2:0] REG_HOUR_DIM    = 3'd7;

	// register reset values
	localparam logic [11:0] RST_LIGHT_MIN  = 12'd0;
	localparam logic [11:0] RST_LIGHT_MAX  = 12'd4095;
	localparam logic [7:0]  RST_MANUAL     = 8'd0;
	localparam logic [23:0] RST_BACKGROUND = 24'h000000;
	localparam logic [23:0] RST_SECOND_COL = 24'h0000FF;
	localparam logic [23:0] RST_MINUTE_COL = 24'h00FF00;
	localparam logic [23:0] RST_HOUR_COL   = 24'hFF0000;
	localparam logic [8:0]  RST_HOUR_DIM   = 9'd64;

	// input word: one clock tick
	typedef struct packed {
		logic [4:0]  hour_now;
		logic [5:0]  minute_now;
		logic [5:0]  second_now;
		logic [11:0] light_level;
	} tick_t;

	// output word: one LED
	typedef struct packed {
		logic [5:0] led_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] strip_brightness;
		logic       last_led;
	} led_t;

	// configuration registers
	typedef struct packed {
		logic [11:0] light_min;
		logic [11:0] light_max;
		logic [7:0]  manual_brightness;
		logic [23:0] background_color;
		logic [23:0] second_color;
		logic [23:0] minute_color;
		logic [23:0] hour_color;
		logic [8:0]  hour_dim;
	} cfg_t;

	// classified frame handed from front to back
	typedef struct packed {
		logic [5:0] second_pos;
		logic [5:0] minute_pos;
		logic [5:0] mark;
		logic [5:0] prog_end;
		logic [7:0] bright;
	} frame_t;

	// frame queue status
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage
`default_nettype wire

[sv/lrcf_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// LED ring renderer - front end
// Accepts a tick, places the hour mark and progress span, and works out the
// frame brightness (bit-serial divider when needed) before queueing the frame.
// ----------------------------------------------------------------------------
module lrcf_front (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	output logic                   busy,
	input  lrcf_pkg::tick_t        tick,
	input  lrcf_pkg::cfg_t         cfg,
	input  lrcf_pkg::queue_status_t qstat,
	output logic                   push,
	output lrcf_pkg::frame_t       frame
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_PUSH = 3'b100
	} front_state_t;

	front_state_t     state_q;
	logic [2:0]       bit_q;
	logic [21:0]      rem_q;
	logic [12:0]      div_q;
	lrcf_pkg::frame_t frame_q;

	logic        take;
	logic [4:0]  hour12;
	logic [5:0]  mark;
	logic [2:0]  prog;
	logic        need_div;
	logic [7:0]  direct_bright;
	logic [21:0] rem_init;
	logic [21:0] shifted;

	// accept while idle, or while the held frame leaves this cycle
	assign busy = (state_q == ST_DIV) || ((state_q == ST_PUSH) && qstat.full);
	assign take = start && !busy;
	assign push = (state_q == ST_PUSH) && !qstat.full;
	assign frame = frame_q;

	// hour mark position on the ring
	always_comb begin
		if (tick.hour_now >= 5'd24) begin
			hour12 = tick.hour_now - 5'd24;
		end else if (tick.hour_now >= 5'd12) begin
			hour12 = tick.hour_now - 5'd12;
		end else begin
			hour12 = tick.hour_now;
		end
		mark = {hour12[3:0], 2'b00} + {2'b00, hour12[3:0]};
	end

	// number of progress positions: minute / 15 + 1
	always_comb begin
		priority if (tick.minute_now < 6'd15) begin
			prog = 3'd1;
		end else if (tick.minute_now < 6'd30) begin
			prog = 3'd2;
		end else if (tick.minute_now < 6'd45) begin
			prog = 3'd3;
		end else if (tick.minute_now < 6'd60) begin
			prog = 3'd4;
		end else begin
			prog = 3'd5;
		end
	end

	// brightness: fixed cases, or rounded light * 255 / max by division
	always_comb begin
		need_div = 1'b0;
		priority if (cfg.manual_brightness != 8'd0) begin
			direct_bright = cfg.manual_brightness;
		end else if (tick.light_level < cfg.light_min) begin
			direct_bright = 8'd0;
		end else if (tick.light_level > cfg.light_max) begin
			direct_bright = 8'd255;
		end else if (cfg.light_max == 12'd0) begin
			direct_bright = 8'd0;
		end else begin
			direct_bright = 8'd0;
			need_div = 1'b1;
		end
	end

	assign rem_init = 22'(tick.light_level) * 22'd510 + 22'(cfg.light_max);
	assign shifted  = 22'(div_q) << bit_q;

	// sequence the front end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= 3'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= need_div ? ST_DIV : ST_PUSH;
						bit_q   <= 3'd7;
					end
				end
				ST_DIV: begin
					bit_q <= bit_q - 3'd1;
					if (bit_q == 3'd0) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (take) begin
						state_q <= need_div ? ST_DIV : ST_PUSH;
						bit_q   <= 3'd7;
					end else if (push) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// capture the word, then restore one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (take) begin
			frame_q.second_pos <= tick.second_now;
			frame_q.minute_pos <= tick.minute_now;
			frame_q.mark       <= mark;
			frame_q.prog_end   <= mark + {3'b000, prog};
			frame_q.bright     <= direct_bright;
			rem_q              <= rem_init;
			div_q              <= {cfg.light_max, 1'b0};
		end else if (state_q == ST_DIV) begin
			if (rem_q >= shifted) begin
				rem_q                 <= rem_q - shifted;
				frame_q.bright[bit_q] <= 1'b1;
			end
		end
	end

	// the last divide step always hands over to the push state
	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) && (bit_q == 3'd0) |=> (state_q == ST_PUSH))
		else $error("divider did not finish into push");

endmodule
`default_nettype wire

[sv/lrcf_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// LED ring renderer - frame queue
// Short first-in first-out store of classified frames between front and back.
// ----------------------------------------------------------------------------
module lrcf_queue #(
	parameter int DEPTH = lrcf_pkg::QUEUE_DEPTH
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     push,
	input  lrcf_pkg::frame_t        wdata,
	input  wire                     pop,
	output lrcf_pkg::frame_t        rdata,
	output lrcf_pkg::queue_status_t status
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	lrcf_pkg::frame_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign rdata        = entry_q[rd_ptr_q];
	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);

	// store the pushed frame
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !status.full)
		else $error("frame pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("frame popped from an empty queue");

endmodule
`default_nettype wire

[sv/lrcf_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// LED ring renderer - back end
// Walks the ring one position a cycle for each queued frame and registers
// the colour and brightness of every LED.
// ----------------------------------------------------------------------------
module lrcf_back (
	input  wire                     clk,
	input  wire                     arst_n,
	input  lrcf_pkg::cfg_t          cfg,
	input  lrcf_pkg::queue_status_t qstat,
	input  lrcf_pkg::frame_t        frame_in,
	output logic                    pop,
	output logic                    led_valid,
	output lrcf_pkg::led_t          led
);

	logic             active_q;
	logic [5:0]       idx_q;
	lrcf_pkg::frame_t frame_q;
	logic             led_valid_s1;
	lrcf_pkg::led_t   led_s1;

	logic        at_last;
	logic [23:0] dimmed;
	logic [23:0] colour;

	// scale one colour byte by the dim factor, saturating
	function automatic logic [7:0] dim_byte(input logic [7:0] c, input logic [8:0] f);
		logic [16:0] prod;
		prod = 17'(c) * 17'(f);
		dim_byte = (prod[16:8] > 9'd255) ? 8'd255 : prod[15:8];
	endfunction

	assign dimmed = {dim_byte(cfg.hour_color[23:16], cfg.hour_dim),
	                 dim_byte(cfg.hour_color[15:8], cfg.hour_dim),
	                 dim_byte(cfg.hour_color[7:0], cfg.hour_dim)};

	assign at_last = (idx_q == lrcf_pkg::LED_LAST);
	assign pop     = !qstat.empty && (!active_q || at_last);

	assign led_valid = led_valid_s1;
	assign led       = led_s1;

	// pick the colour of the current position, hands first
	always_comb begin
		priority if (idx_q == frame_q.second_pos) begin
			colour = cfg.second_color;
		end else if (idx_q == frame_q.minute_pos) begin
			colour = cfg.minute_color;
		end else if (idx_q == frame_q.mark) begin
			colour = cfg.hour_color;
		end else if ((idx_q > frame_q.mark) && (idx_q <= frame_q.prog_end)) begin
			colour = dimmed;
		end else if (idx_q <= frame_q.minute_pos) begin
			colour = cfg.minute_color;
		end else if (idx_q <= frame_q.second_pos) begin
			colour = cfg.second_color;
		end else begin
			colour = cfg.background_color;
		end
	end

	// advance the ring walk, taking a frame when idle or on the last position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			idx_q        <= 6'd0;
			led_valid_s1 <= 1'b0;
		end else begin
			led_valid_s1 <= active_q;
			if (pop) begin
				active_q <= 1'b1;
				idx_q    <= 6'd0;
			end else if (active_q) begin
				if (at_last) begin
					active_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 6'd1;
				end
			end
		end
	end

	// hold the frame and register the output word
	always_ff @(posedge clk) begin
		if (pop) begin
			frame_q <= frame_in;
		end
		led_s1.led_index        <= idx_q;
		led_s1.red              <= colour[23:16];
		led_s1.green            <= colour[15:8];
		led_s1.blue             <= colour[7:0];
		led_s1.strip_brightness <= frame_q.bright;
		led_s1.last_led         <= at_last;
	end

	a_walk_steps: assert property (@(posedge clk) disable iff (!arst_n)
		led_valid_s1 && !led_s1.last_led |=>
			led_valid_s1 && (led_s1.led_index == $past(led_s1.led_index) + 6'd1))
		else $error("ring walk skipped or stalled mid-frame");

	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		led_valid_s1 && led_s1.last_led |-> (led_s1.led_index == lrcf_pkg::LED_LAST))
		else $error("last LED flag away from ring end");

endmodule
`default_nettype wire

[sv/led_ring_clock_face_renderer.sv]
`default_nettype none
// Path: the 8-step brightness divider runs first when the light level needs it;
//   then the front end frame, queue, back end frame and output registers.
// Throughput: one LED word a cycle while a frame is drawn, set by the ring walk in the
//   back end; a tick may be taken while the previous frame is still being drawn.
// Reset: registers with a reset return to their reset values at once, no clearing pass.
// The receiver cannot stall: each LED word is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// LED ring clock face renderer - top level
// Configuration registers on an APB-style port, front end, frame queue and
// ring walking back end.
// ----------------------------------------------------------------------------
module led_ring_clock_face_renderer #(
	parameter int QUEUE_DEPTH = lrcf_pkg::QUEUE_DEPTH
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	output logic                       busy,
	input  lrcf_pkg::tick_t            tick,
	output logic                       led_valid,
	output lrcf_pkg::led_t             led,
	input  wire                        psel,
	input  wire                        penable,
	input  wire                        pwrite,
	input  wire [lrcf_pkg::ADDR_W-1:0] paddr,
	input  wire [31:0]                 pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	lrcf_pkg::cfg_t          cfg_q;
	lrcf_pkg::queue_status_t qstat;
	lrcf_pkg::frame_t        push_frame;
	lrcf_pkg::frame_t        pop_frame;
	logic                    push;
	logic                    pop;
	logic                    wr_en;
	logic [2:0]              reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.light_min         <= lrcf_pkg::RST_LIGHT_MIN;
			cfg_q.light_max         <= lrcf_pkg::RST_LIGHT_MAX;
			cfg_q.manual_brightness <= lrcf_pkg::RST_MANUAL;
			cfg_q.background_color  <= lrcf_pkg::RST_BACKGROUND;
			cfg_q.second_color      <= lrcf_pkg::RST_SECOND_COL;
			cfg_q.minute_color      <= lrcf_pkg::RST_MINUTE_COL;
			cfg_q.hour_color        <= lrcf_pkg::RST_HOUR_COL;
			cfg_q.hour_dim          <= lrcf_pkg::RST_HOUR_DIM;
		end else if (wr_en) begin
			unique case (reg_idx)
				lrcf_pkg::REG_LIGHT_MIN:  cfg_q.light_min         <= pwdata[11:0];
				lrcf_pkg::REG_LIGHT_MAX:  cfg_q.light_max         <= pwdata[11:0];
				lrcf_pkg::REG_MANUAL:     cfg_q.manual_brightness <= pwdata[7:0];
				lrcf_pkg::REG_BACKGROUND: cfg_q.background_color  <= pwdata[23:0];
				lrcf_pkg::REG_SECOND_COL: cfg_q.second_color      <= pwdata[23:0];
				lrcf_pkg::REG_MINUTE_COL: cfg_q.minute_color      <= pwdata[23:0];
				lrcf_pkg::REG_HOUR_COL:   cfg_q.hour_color        <= pwdata[23:0];
				lrcf_pkg::REG_HOUR_DIM:   cfg_q.hour_dim          <= pwdata[8:0];
			endcase
		end
	end

	// read back configuration registers
	always_comb begin
		unique case (reg_idx)
			lrcf_pkg::REG_LIGHT_MIN:  prdata = 32'(cfg_q.light_min);
			lrcf_pkg::REG_LIGHT_MAX:  prdata = 32'(cfg_q.light_max);
			lrcf_pkg::REG_MANUAL:     prdata = 32'(cfg_q.manual_brightness);
			lrcf_pkg::REG_BACKGROUND: prdata = 32'(cfg_q.background_color);
			lrcf_pkg::REG_SECOND_COL: prdata = 32'(cfg_q.second_color);
			lrcf_pkg::REG_MINUTE_COL: prdata = 32'(cfg_q.minute_color);
			lrcf_pkg::REG_HOUR_COL:   prdata = 32'(cfg_q.hour_color);
			lrcf_pkg::REG_HOUR_DIM:   prdata = 32'(cfg_q.hour_dim);
		endcase
	end

	lrcf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.tick   (tick),
		.cfg    (cfg_q),
		.qstat  (qstat),
		.push   (push),
		.frame  (push_frame)
	);

	lrcf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_frame),
		.pop    (pop),
		.rdata  (pop_frame),
		.status (qstat)
	);

	lrcf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.qstat     (qstat),
		.frame_in  (pop_frame),
		.pop       (pop),
		.led_valid (led_valid),
		.led       (led)
	);

endmodule
`default_nettype wire
